### rtl/bank_switch_mapper_with_scanline_irq_core_macros.svh
// Assertion macros for the bank-switch mapper core.
// Used by rtl/bsm_state.sv and the top level; no other dependencies.
`ifndef BANK_SWITCH_MAPPER_WITH_SCANLINE_IRQ_CORE_MACROS_SVH
`define BANK_SWITCH_MAPPER_WITH_SCANLINE_IRQ_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define BSM_ASSERT_IMP(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bsm assertion failed");
`define BSM_ASSERT_NXT(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bsm assertion failed");
`else
`define BSM_ASSERT_IMP(lbl, ck, rstn, ante, cons)
`define BSM_ASSERT_NXT(lbl, ck, rstn, ante, cons)
`endif
`endif

### rtl/bsm_pkg.sv
// Shared types and constants of the bank-switch mapper core.
// No dependencies; imported by every RTL module.
`default_nettype none
package bsm_pkg;

    typedef enum logic [1:0] {
        ACT_CPU_WRITE = 2'd0,
        ACT_PPU_DOT   = 2'd1,
        ACT_CPU_TICK  = 2'd2
    } action_t;

    localparam logic [2:0] GRP_BANK      = 3'b100;
    localparam logic [2:0] GRP_MIRROR    = 3'b101;
    localparam logic [2:0] GRP_IRQ_LATCH = 3'b110;
    localparam logic [2:0] GRP_IRQ_ACK   = 3'b111;

    localparam logic [3:0] CMD_IDX_CHR0 = 4'd0;
    localparam logic [3:0] CMD_IDX_CHR2 = 4'd1;
    localparam logic [3:0] CMD_IDX_CHR4 = 4'd2;
    localparam logic [3:0] CMD_IDX_CHR5 = 4'd3;
    localparam logic [3:0] CMD_IDX_CHR6 = 4'd4;
    localparam logic [3:0] CMD_IDX_CHR7 = 4'd5;
    localparam logic [3:0] CMD_IDX_PRG0 = 4'd6;
    localparam logic [3:0] CMD_IDX_PRG1 = 4'd7;
    localparam logic [3:0] CMD_IDX_CHR1 = 4'd8;
    localparam logic [3:0] CMD_IDX_CHR3 = 4'd9;
    localparam logic [3:0] CMD_IDX_PRG2 = 4'd15;

    localparam int CMD_CHR_INVERT_BIT = 7;
    localparam int CMD_PRG_SWAP_BIT   = 6;
    localparam int CMD_CHR_1K_BIT     = 5;

    localparam logic [7:0] PRG_RESET       = 8'hFF;
    localparam logic [8:0] IRQ_CLOCK_DOT   = 9'd264;
    localparam logic [2:0] PRESCALE_RELOAD = 3'd4;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] address;
        logic [7:0]  value;
        logic [8:0]  ppu_dot;
        logic        rendering;
    } req_t;

    typedef struct packed {
        logic [7:0]      command;
        logic [2:0][7:0] prg;
        logic [7:0][7:0] chr;
        logic            mirror;
        logic            irq_line;
    } bank_state_t;

    typedef struct packed {
        logic        irq_asserted;
        logic        mirror_horizontal;
        logic [7:0]  prg_bank_8000;
        logic [7:0]  prg_bank_a000;
        logic [7:0]  prg_bank_c000;
        logic [31:0] chr_banks_lower;
        logic [31:0] chr_banks_upper;
    } result_t;

endpackage
`default_nettype wire

### rtl/bank_switch_mapper_with_scanline_irq_core.sv
// Top level of the bank-switch mapper with scanline IRQ: request register,
// state update (bsm_state), mapping (bsm_map) and result register.
// Depends on bsm_pkg, bsm_state, bsm_map and the core macros header.
//
//   channel  | handshake              | payload
//   request  | in_valid / in_ready    | action, address, value, ppu_dot, rendering
//   result   | out_valid / out_ready  | irq_asserted .. chr_banks_upper
//
// An accepted request passes the request register, then the result register, where it becomes valid.
// One request per cycle sustained while out_ready holds; state updates as the request leaves its register.
// Reset (rst_n low, asynchronous) restores all mapper state and empties both stages.
// A stalled result holds the request stage; in_ready drops only when both are full.
`default_nettype none
`include "bank_switch_mapper_with_scanline_irq_core_macros.svh"
module bank_switch_mapper_with_scanline_irq_core (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire  [1:0]  action,
    input  wire  [15:0] address,
    input  wire  [7:0]  value,
    input  wire  [8:0]  ppu_dot,
    input  wire         rendering,
    output logic        out_valid,
    input  wire         out_ready,
    output logic        irq_asserted,
    output logic        mirror_horizontal,
    output logic [7:0]  prg_bank_8000,
    output logic [7:0]  prg_bank_a000,
    output logic [7:0]  prg_bank_c000,
    output logic [31:0] chr_banks_lower,
    output logic [31:0] chr_banks_upper
);
    import bsm_pkg::*;

    logic        req_valid_reg;
    req_t        req_reg;
    logic        res_valid_reg;
    result_t     res_reg;
    logic        advance;
    bank_state_t state_next;
    result_t     res_next;

    assign advance  = req_valid_reg && (!res_valid_reg || out_ready);
    assign in_ready = !req_valid_reg || advance;

    bsm_state u_state (
        .clk        (clk),
        .rst_n      (rst_n),
        .upd        (advance),
        .req        (req_reg),
        .state_next (state_next)
    );

    bsm_map u_map (
        .st  (state_next),
        .res (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                req_valid_reg <= in_valid;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg.action    <= action;
            req_reg.address   <= address;
            req_reg.value     <= value;
            req_reg.ppu_dot   <= ppu_dot;
            req_reg.rendering <= rendering;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid         = res_valid_reg;
    assign irq_asserted      = res_reg.irq_asserted;
    assign mirror_horizontal = res_reg.mirror_horizontal;
    assign prg_bank_8000     = res_reg.prg_bank_8000;
    assign prg_bank_a000     = res_reg.prg_bank_a000;
    assign prg_bank_c000     = res_reg.prg_bank_c000;
    assign chr_banks_lower   = res_reg.chr_banks_lower;
    assign chr_banks_upper   = res_reg.chr_banks_upper;

    `BSM_ASSERT_NXT(a_advance_fills_result, clk, rst_n, advance, res_valid_reg)
    `BSM_ASSERT_IMP(a_ready_when_result_free, clk, rst_n, !res_valid_reg, in_ready)
    `BSM_ASSERT_NXT(a_stalled_request_held, clk, rst_n,
        req_valid_reg && !advance, req_valid_reg && $stable(req_reg))

endmodule
`default_nettype wire

### rtl/bsm_state.sv
// Mapper registers and scanline IRQ counter; applies one request per update.
// Depends on bsm_pkg and the core macros header.
`default_nettype none
`include "bank_switch_mapper_with_scanline_irq_core_macros.svh"
module bsm_state (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 upd,
    input  wire bsm_pkg::req_t  req,
    output bsm_pkg::bank_state_t state_next
);
    import bsm_pkg::*;

    logic [7:0]      command_reg, command_next;
    logic [2:0][7:0] prg_reg, prg_next;
    logic [7:0][7:0] chr_reg, chr_next;
    logic            mirror_reg, mirror_next;
    logic            irq_enable_reg, irq_enable_next;
    logic [7:0]      irq_count_reg, irq_count_next;
    logic [7:0]      irq_reload_reg, irq_reload_next;
    logic            irq_cpu_mode_reg, irq_cpu_mode_next;
    logic            reload_pending_reg, reload_pending_next;
    logic [2:0]      prescaler_reg, prescaler_next;
    logic            irq_line_reg, irq_line_next;

    logic            counter_clk;
    logic [2:0]      prescale_dec;
    logic [2:0]      group;
    logic            odd;

    assign group        = req.address[15:13];
    assign odd          = req.address[0];
    assign prescale_dec = prescaler_reg - 3'd1;

    always_comb
    begin
        command_next        = command_reg;
        prg_next            = prg_reg;
        chr_next            = chr_reg;
        mirror_next         = mirror_reg;
        irq_enable_next     = irq_enable_reg;
        irq_count_next      = irq_count_reg;
        irq_reload_next     = irq_reload_reg;
        irq_cpu_mode_next   = irq_cpu_mode_reg;
        reload_pending_next = reload_pending_reg;
        prescaler_next      = prescaler_reg;
        irq_line_next       = irq_line_reg;
        counter_clk         = 1'b0;

        case (req.action)
            ACT_CPU_WRITE:
            begin
                if (req.address[15])
                begin
                    case (group)
                        GRP_BANK:
                        begin
                            if (!odd)
                            begin
                                command_next = req.value;
                            end
                            else
                            begin
                                case (command_reg[3:0])
                                    CMD_IDX_CHR0: chr_next[0] = req.value;
                                    CMD_IDX_CHR2: chr_next[2] = req.value;
                                    CMD_IDX_CHR4: chr_next[4] = req.value;
                                    CMD_IDX_CHR5: chr_next[5] = req.value;
                                    CMD_IDX_CHR6: chr_next[6] = req.value;
                                    CMD_IDX_CHR7: chr_next[7] = req.value;
                                    CMD_IDX_PRG0: prg_next[0] = req.value;
                                    CMD_IDX_PRG1: prg_next[1] = req.value;
                                    CMD_IDX_CHR1: chr_next[1] = req.value;
                                    CMD_IDX_CHR3: chr_next[3] = req.value;
                                    CMD_IDX_PRG2: prg_next[2] = req.value;
                                    default: ;
                                endcase
                            end
                        end
                        GRP_MIRROR:
                        begin
                            if (!odd)
                            begin
                                mirror_next = req.value[0];
                            end
                        end
                        GRP_IRQ_LATCH:
                        begin
                            if (odd)
                            begin
                                irq_cpu_mode_next   = req.value[0];
                                reload_pending_next = 1'b1;
                            end
                            else
                            begin
                                irq_reload_next = req.value;
                            end
                        end
                        GRP_IRQ_ACK:
                        begin
                            irq_enable_next = odd;
                            if (!odd)
                            begin
                                irq_line_next = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ACT_PPU_DOT:
            begin
                counter_clk = !irq_cpu_mode_reg && req.rendering
                              && (req.ppu_dot == IRQ_CLOCK_DOT);
            end
            ACT_CPU_TICK:
            begin
                if (irq_cpu_mode_reg)
                begin
                    prescaler_next = prescale_dec;
                    if (prescale_dec == 3'd0)
                    begin
                        prescaler_next = PRESCALE_RELOAD;
                        counter_clk    = 1'b1;
                    end
                end
            end
            default: ;
        endcase

        if (counter_clk)
        begin
            if ((irq_count_reg == 8'd0) || reload_pending_reg)
            begin
                irq_count_next      = irq_reload_reg + {7'd0, reload_pending_reg};
                reload_pending_next = 1'b0;
            end
            else
            begin
                irq_count_next = irq_count_reg - 8'd1;
                if ((irq_count_next == 8'd0) && irq_enable_reg)
                begin
                    irq_line_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            command_reg        <= 8'd0;
            prg_reg            <= {3{PRG_RESET}};
            for (int i = 0; i < 8; i++)
            begin
                chr_reg[i] <= 8'(i);
            end
            mirror_reg         <= 1'b0;
            irq_enable_reg     <= 1'b0;
            irq_count_reg      <= 8'd0;
            irq_reload_reg     <= 8'd0;
            irq_cpu_mode_reg   <= 1'b0;
            reload_pending_reg <= 1'b0;
            prescaler_reg      <= PRESCALE_RELOAD;
            irq_line_reg       <= 1'b0;
        end
        else if (upd)
        begin
            command_reg        <= command_next;
            prg_reg            <= prg_next;
            chr_reg            <= chr_next;
            mirror_reg         <= mirror_next;
            irq_enable_reg     <= irq_enable_next;
            irq_count_reg      <= irq_count_next;
            irq_reload_reg     <= irq_reload_next;
            irq_cpu_mode_reg   <= irq_cpu_mode_next;
            reload_pending_reg <= reload_pending_next;
            prescaler_reg      <= prescaler_next;
            irq_line_reg       <= irq_line_next;
        end
    end

    assign state_next.command  = command_next;
    assign state_next.prg      = prg_next;
    assign state_next.chr      = chr_next;
    assign state_next.mirror   = mirror_next;
    assign state_next.irq_line = irq_line_next;

    `BSM_ASSERT_IMP(a_prescaler_range, clk, rst_n, 1'b1,
        (prescaler_reg != 3'd0) && (prescaler_reg <= PRESCALE_RELOAD))
    `BSM_ASSERT_IMP(a_irq_rise_enabled, clk, rst_n, $rose(irq_line_reg),
        irq_enable_reg)
    `BSM_ASSERT_NXT(a_irq_ack_clears, clk, rst_n,
        upd && (req.action == ACT_CPU_WRITE) && (req.address[15:13] == GRP_IRQ_ACK)
            && !req.address[0],
        !irq_line_reg && !irq_enable_reg)

endmodule
`default_nettype wire

### rtl/bsm_map.sv
// Slot mapping: PRG slot rotation and CHR 2KB pairing and half swap.
// Depends on bsm_pkg.
`default_nettype none
module bsm_map (
    input  wire bsm_pkg::bank_state_t st,
    output bsm_pkg::result_t          res
);
    import bsm_pkg::*;

    logic [3:0][7:0] half_a;
    logic [3:0][7:0] half_b;

    always_comb
    begin
        if (st.command[CMD_CHR_1K_BIT])
        begin
            half_a = {st.chr[3], st.chr[2], st.chr[1], st.chr[0]};
        end
        else
        begin
            half_a = {st.chr[2] | 8'h01, st.chr[2] & 8'hFE,
                      st.chr[0] | 8'h01, st.chr[0] & 8'hFE};
        end
        half_b = {st.chr[7], st.chr[6], st.chr[5], st.chr[4]};

        res.irq_asserted      = st.irq_line;
        res.mirror_horizontal = st.mirror;

        if (st.command[CMD_CHR_INVERT_BIT])
        begin
            res.chr_banks_lower = half_b;
            res.chr_banks_upper = half_a;
        end
        else
        begin
            res.chr_banks_lower = half_a;
            res.chr_banks_upper = half_b;
        end

        if (st.command[CMD_PRG_SWAP_BIT])
        begin
            res.prg_bank_8000 = st.prg[2];
            res.prg_bank_a000 = st.prg[0];
            res.prg_bank_c000 = st.prg[1];
        end
        else
        begin
            res.prg_bank_8000 = st.prg[0];
            res.prg_bank_a000 = st.prg[1];
            res.prg_bank_c000 = st.prg[2];
        end
    end

endmodule
`default_nettype wire
